@@ rtl/blist_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, field widths and operation codes for the bounded list engine.
package blist_pkg;

    // Default sizing of the element store.
    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_ELEM_WIDTH = 32;

    // Fixed widths of the request and result fields.
    localparam int KIND_W = 4;
    localparam int POS_W  = 9;
    localparam int VAL_W  = 32;
    localparam int DATA_W = 32;
    localparam int FPOS_W = 8;
    localparam int CNT_W  = 9;
    localparam int LEN_W  = 9;
    localparam int STAT_W = 2;

    // Operation codes carried in the kind field.
    typedef enum logic [KIND_W-1:0] {
        K_APPEND = 4'd0,
        K_POP    = 4'd1,
        K_GET    = 4'd2,
        K_SET    = 4'd3,
        K_INSERT = 4'd4,
        K_REMOVE = 4'd5,
        K_CLEAR  = 4'd6,
        K_COUNT  = 4'd7,
        K_FIRST  = 4'd8,
        K_LAST   = 4'd9
    } t_kind;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic init;
        logic rd;
        logic wr_val;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic err;
        logic needs_read;
        logic needs_write;
        logic last_rd;
    } t_dp_stat;

endpackage

@@ rtl/blist_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencing state machine of the bounded list engine.
module blist_ctrl
    import blist_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    output logic     o_busy,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_DRAIN,
        S_WRITE,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_busy;

    // State and the registered busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_CHECK;
                        r_busy  <= 1'b1;
                    end
                end
                S_CHECK: begin
                    priority if (i_stat.err) begin
                        r_state <= S_DONE;
                    end else if (i_stat.needs_read) begin
                        r_state <= S_READ;
                    end else if (i_stat.needs_write) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_READ: begin
                    if (i_stat.last_rd) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= i_stat.needs_write ? S_WRITE : S_DONE;
                end
                S_WRITE: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    // Datapath commands decoded from the current state.
    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = (r_state == S_IDLE) && i_start;
        o_cmd.init    = (r_state == S_CHECK) && !i_stat.err && i_stat.needs_read;
        o_cmd.rd      = (r_state == S_READ);
        o_cmd.wr_val  = (r_state == S_WRITE);
        o_cmd.finish  = (r_state == S_DONE);
    end

    assign o_busy = r_busy;

endmodule

@@ rtl/blist_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the bounded list engine: element memory, length, walk pointers and results.
module blist_dp
    import blist_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [POS_W-1:0]  i_position,
    input  logic [VAL_W-1:0]  i_element_value,
    output logic              o_done,
    output logic [DATA_W-1:0] o_data_out,
    output logic [FPOS_W-1:0] o_found_position,
    output logic              o_found,
    output logic [CNT_W-1:0]  o_match_count,
    output logic [LEN_W-1:0]  o_length_out,
    output logic [STAT_W-1:0] o_status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > POS_W) ? LW : POS_W;
    localparam int VW = (ELEM_WIDTH < VAL_W) ? ELEM_WIDTH : VAL_W;
    localparam int RW = (ELEM_WIDTH < DATA_W) ? ELEM_WIDTH : DATA_W;

    // Captured request.
    logic [KIND_W-1:0]     r_kind;
    logic [POS_W-1:0]      r_pos;
    logic [ELEM_WIDTH-1:0] r_val;

    // List length.
    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;

    // Memory walk.
    logic [ELEM_WIDTH-1:0] r_mem [CAPACITY];
    logic [ELEM_WIDTH-1:0] r_rdata;
    logic [AW-1:0]         r_ptr;
    logic [AW-1:0]         r_end;
    logic                  r_dn;
    logic                  r_ret_vld;
    logic [AW-1:0]         r_ret_addr;

    // Accumulated result of the walk.
    logic [LW-1:0] r_cnt;
    logic          r_found;
    logic [AW-1:0] r_fpos;
    logic [RW-1:0] r_data;

    // Result registers.
    logic              r_o_vld;
    logic [RW-1:0]     r_o_data;
    logic [FPOS_W-1:0] r_o_fpos;
    logic              r_o_found;
    logic [CNT_W-1:0]  r_o_cnt;
    logic [LEN_W-1:0]  r_o_len;
    t_status           r_o_status;

    // Decoded operation checks.
    logic [CW-1:0] pos_c;
    logic [CW-1:0] len_c;
    logic [AW-1:0] pos_a;
    logic [AW-1:0] len_a;
    logic [AW-1:0] len_m1;
    logic          is_full;
    logic          is_empty;
    logic          pos_ge;
    logic          pos_gt;
    logic          is_match;
    t_status       st;
    logic          need_rd;
    logic          need_wr;
    logic [AW-1:0] ptr0;
    logic [AW-1:0] end0;

    // Memory write port.
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ELEM_WIDTH-1:0] wr_data;

    assign pos_c    = CW'(r_pos);
    assign len_c    = CW'(r_len);
    assign pos_a    = AW'(r_pos);
    assign len_a    = AW'(r_len);
    assign len_m1   = AW'(r_len - LW'(1));
    assign is_full  = (r_len == LW'(CAPACITY));
    assign is_empty = (r_len == '0);
    assign pos_ge   = (pos_c >= len_c);
    assign pos_gt   = (pos_c > len_c);
    assign is_match = (r_rdata == r_val);

    // Bounds checks, walk range and the length after the operation.
    always_comb begin
        st      = ST_OK;
        need_rd = 1'b0;
        need_wr = 1'b0;
        ptr0    = '0;
        end0    = len_m1;
        n_len   = r_len;
        unique case (r_kind)
            K_APPEND: begin
                if (is_full) begin
                    st = ST_FULL;
                end else begin
                    need_wr = 1'b1;
                    n_len   = r_len + LW'(1);
                end
            end
            K_POP: begin
                if (is_empty) begin
                    st = ST_EMPTY;
                end else begin
                    need_rd = 1'b1;
                    ptr0    = len_m1;
                    n_len   = r_len - LW'(1);
                end
            end
            K_GET: begin
                if (pos_ge) begin
                    st = ST_RANGE;
                end else begin
                    need_rd = 1'b1;
                    ptr0    = pos_a;
                    end0    = pos_a;
                end
            end
            K_SET: begin
                if (pos_ge) begin
                    st = ST_RANGE;
                end else begin
                    need_wr = 1'b1;
                end
            end
            K_INSERT: begin
                priority if (pos_gt) begin
                    st = ST_RANGE;
                end else if (is_full) begin
                    st = ST_FULL;
                end else begin
                    // Entries from the end down to the position move up by one.
                    need_rd = !pos_ge;
                    need_wr = 1'b1;
                    ptr0    = len_m1;
                    end0    = pos_a;
                    n_len   = r_len + LW'(1);
                end
            end
            K_REMOVE: begin
                if (pos_ge) begin
                    st = ST_RANGE;
                end else begin
                    need_rd = 1'b1;
                    ptr0    = pos_a;
                    n_len   = r_len - LW'(1);
                end
            end
            K_CLEAR: begin
                n_len = '0;
            end
            K_COUNT, K_FIRST, K_LAST: begin
                need_rd = !is_empty;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.err         = (st != ST_OK);
    assign o_stat.needs_read  = need_rd;
    assign o_stat.needs_write = need_wr;
    assign o_stat.last_rd     = (r_ptr == r_end);

    // Write port: the new value, or a returned word moved one place up or down.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pos_a;
        wr_data = r_rdata;
        priority if (i_cmd.wr_val) begin
            wr_en   = 1'b1;
            wr_data = r_val;
            wr_addr = (r_kind == K_APPEND) ? len_a : pos_a;
        end else if (r_ret_vld && (r_kind == K_INSERT)) begin
            wr_en   = 1'b1;
            wr_addr = r_ret_addr + AW'(1);
        end else if (r_ret_vld && (r_kind == K_REMOVE) && (r_ret_addr != pos_a)) begin
            wr_en   = 1'b1;
            wr_addr = r_ret_addr - AW'(1);
        end else begin
            wr_en = 1'b0;
        end
    end

    // Element memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_ptr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_ret_vld <= 1'b0;
            r_o_vld   <= 1'b0;
        end else begin
            r_ret_vld <= i_cmd.rd;
            r_o_vld   <= i_cmd.finish;
            if (i_cmd.finish) begin
                r_len <= n_len;
            end
        end
    end

    // Request capture, walk pointers, accumulation and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_pos   <= i_position;
            r_val   <= ELEM_WIDTH'(i_element_value[VW-1:0]);
            r_cnt   <= '0;
            r_found <= 1'b0;
            r_fpos  <= '0;
            r_data  <= '0;
        end
        if (i_cmd.init) begin
            r_ptr <= ptr0;
            r_end <= end0;
            r_dn  <= (r_kind == K_INSERT);
        end
        if (i_cmd.rd) begin
            r_ret_addr <= r_ptr;
            r_ptr      <= r_dn ? (r_ptr - AW'(1)) : (r_ptr + AW'(1));
        end
        if (r_ret_vld) begin
            unique case (r_kind)
                K_POP, K_GET: begin
                    r_data <= r_rdata[RW-1:0];
                end
                K_REMOVE: begin
                    if (r_ret_addr == pos_a) begin
                        r_data <= r_rdata[RW-1:0];
                    end
                end
                K_COUNT: begin
                    if (is_match) begin
                        r_cnt <= r_cnt + LW'(1);
                    end
                end
                K_FIRST: begin
                    if (is_match && !r_found) begin
                        r_found <= 1'b1;
                        r_fpos  <= r_ret_addr;
                    end
                end
                K_LAST: begin
                    // An ascending walk keeps the latest match.
                    if (is_match) begin
                        r_found <= 1'b1;
                        r_fpos  <= r_ret_addr;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.finish) begin
            r_o_data   <= r_data;
            r_o_fpos   <= FPOS_W'(r_fpos);
            r_o_found  <= r_found;
            r_o_cnt    <= CNT_W'(r_cnt);
            r_o_len    <= LEN_W'(n_len);
            r_o_status <= st;
        end
    end

    assign o_done           = r_o_vld;
    assign o_data_out       = DATA_W'(r_o_data);
    assign o_found_position = r_o_fpos;
    assign o_found          = r_o_found;
    assign o_match_count    = r_o_cnt;
    assign o_length_out     = r_o_len;
    assign o_status         = r_o_status;

`ifndef NO_ASSERTIONS
    // The length never exceeds the capacity.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(CAPACITY))
        else $error("list length above capacity");

    // A value write never meets a shifted word on the single write port.
    a_wr_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.wr_val && r_ret_vld))
        else $error("value write collides with a shift write");

    // The length moves only when a request finishes.
    a_len_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.finish |=> $stable(r_len))
        else $error("length changed outside request completion");
`endif

endmodule

@@ rtl/bounded_list_engine.sv @@
`timescale 1ns / 1ps
// Top level of the bounded list engine: controller and datapath.
//
//  Channel   Handshake            Fields
//  request   start / busy         i_kind, i_position, i_element_value
//  result    o_done (one cycle)   o_data_out, o_found_position, o_found,
//                                 o_match_count, o_length_out, o_status
//
// A request is taken when start is high and busy is low; busy stays high
// until the result is registered. Refused requests, clear, unused kinds and
// searches of an empty list go from the check state to done; append, set
// and insert at the end pass the write state between. Requests that read
// walk their entries in the read state, then drain (insert then writes):
// one entry for pop and get, the whole length for count and index
// searches, length minus position for insert and remove.
// The single read port of the element memory sets that walk at one entry
// per cycle. Of the list state, reset clears only the length; the store
// needs no clearing pass. The receiver cannot stall, and the next request
// may be taken in the cycle o_done is shown.
module bounded_list_engine
    import blist_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [POS_W-1:0]  i_position,
    input  logic [VAL_W-1:0]  i_element_value,
    output logic              o_done,
    output logic [DATA_W-1:0] o_data_out,
    output logic [FPOS_W-1:0] o_found_position,
    output logic              o_found,
    output logic [CNT_W-1:0]  o_match_count,
    output logic [LEN_W-1:0]  o_length_out,
    output logic [STAT_W-1:0] o_status
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer.
    blist_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    // Storage and result datapath.
    blist_dp #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_kind           (i_kind),
        .i_position       (i_position),
        .i_element_value  (i_element_value),
        .o_done           (o_done),
        .o_data_out       (o_data_out),
        .o_found_position (o_found_position),
        .o_found          (o_found),
        .o_match_count    (o_match_count),
        .o_length_out     (o_length_out),
        .o_status         (o_status)
    );

`ifndef NO_ASSERTIONS
    // An accepted request raises busy on the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted request");

    // A result is shown only once the engine is free again.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // Each request gives a single one-cycle strobe.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");
`endif

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the bounded list engine with a shadow list predictor.
module testbench;
    import blist_pkg::*;

    // Kind codes that name no operation, and the widest position code.
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd10;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;
    localparam logic [POS_W-1:0]  POS_MAX        = {POS_W{1'b1}};
    localparam logic [VAL_W-1:0]  VAL_ONES       = {VAL_W{1'b1}};
    localparam int                RANDOM_ITEMS   = 1875;
    localparam int                SETTLE_CYCLES  = 300;

    // One result as the engine should report it.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [FPOS_W-1:0] fpos;
        logic              found;
        logic [CNT_W-1:0]  count;
        logic [LEN_W-1:0]  length;
        logic [STAT_W-1:0] status;
    } t_list_result;

    // Shadow copy of the list that predicts every result and checks it on arrival.
    class list_shadow;
        logic [VAL_W-1:0] words [DEF_CAPACITY];
        int               count_now;
        t_list_result     awaited_results [$];
        int               errors;

        function new();
            count_now = 0;
            errors    = 0;
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

        // Apply one accepted request to the shadow list and queue its result.
        function void record_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                     logic [VAL_W-1:0] val);
            t_list_result r;
            int idx;
            bit hit;
            r = '0;
            r.status = ST_OK;
            hit = 1'b0;
            case (kind)
                K_APPEND: begin
                    if (count_now >= DEF_CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        words[count_now] = val;
                        count_now++;
                    end
                end
                K_POP: begin
                    if (count_now == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        count_now--;
                        r.data = words[count_now];
                    end
                end
                K_GET: begin
                    if (pos >= count_now) r.status = ST_RANGE;
                    else r.data = words[pos];
                end
                K_SET: begin
                    if (pos >= count_now) r.status = ST_RANGE;
                    else words[pos] = val;
                end
                K_INSERT: begin
                    // The range check wins over the full check.
                    if (pos > count_now) begin
                        r.status = ST_RANGE;
                    end else if (count_now >= DEF_CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        for (idx = count_now; idx > pos; idx--) words[idx] = words[idx-1];
                        words[pos] = val;
                        count_now++;
                    end
                end
                K_REMOVE: begin
                    if (pos >= count_now) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.data = words[pos];
                        for (idx = pos; idx + 1 < count_now; idx++) words[idx] = words[idx+1];
                        count_now--;
                    end
                end
                K_CLEAR: begin
                    // Only the length drops; the stored words stay behind.
                    count_now = 0;
                end
                K_COUNT: begin
                    for (idx = 0; idx < count_now; idx++)
                        if (words[idx] == val) r.count = r.count + 1'b1;
                end
                K_FIRST: begin
                    for (idx = 0; idx < count_now && !hit; idx++) begin
                        if (words[idx] == val) begin
                            hit    = 1'b1;
                            r.fpos = idx[FPOS_W-1:0];
                        end
                    end
                    r.found = hit;
                end
                K_LAST: begin
                    for (idx = count_now - 1; idx >= 0 && !hit; idx--) begin
                        if (words[idx] == val) begin
                            hit    = 1'b1;
                            r.fpos = idx[FPOS_W-1:0];
                        end
                    end
                    r.found = hit;
                end
                default: ;
            endcase
            r.length = count_now[LEN_W-1:0];
            awaited_results.push_back(r);
        endfunction

        // Compare one reported result with the oldest prediction, field by field.
        function void check_result(t_list_result got);
            t_list_result want;
            if (awaited_results.size() == 0) begin
                $error("result reported with no request waiting for one");
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.data !== want.data) begin
                $error("data_out: expected %0h, got %0h", want.data, got.data);
                errors++;
            end
            if (got.fpos !== want.fpos) begin
                $error("found_position: expected %0d, got %0d", want.fpos, got.fpos);
                errors++;
            end
            if (got.found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                errors++;
            end
            if (got.count !== want.count) begin
                $error("match_count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
            if (got.length !== want.length) begin
                $error("length_out: expected %0d, got %0d", want.length, got.length);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [KIND_W-1:0] i_kind;
    logic [POS_W-1:0]  i_position;
    logic [VAL_W-1:0]  i_element_value;
    logic              o_done;
    logic [DATA_W-1:0] o_data_out;
    logic [FPOS_W-1:0] o_found_position;
    logic              o_found;
    logic [CNT_W-1:0]  o_match_count;
    logic [LEN_W-1:0]  o_length_out;
    logic [STAT_W-1:0] o_status;

    list_shadow sb;
    int         burst_left;

    bounded_list_engine dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_position       (i_position),
        .i_element_value  (i_element_value),
        .o_done           (o_done),
        .o_data_out       (o_data_out),
        .o_found_position (o_found_position),
        .o_found          (o_found),
        .o_match_count    (o_match_count),
        .o_length_out     (o_length_out),
        .o_status         (o_status)
    );

    // Clock with a 20 ns period.
    always #10 i_clk = ~i_clk;

    // Result monitor: every strobed result is checked at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done !== 1'b0) begin
            sb.check_result('{o_data_out, o_found_position, o_found, o_match_count,
                              o_length_out, o_status});
        end
    end

    // Pause the sender for a random time; long pauses are rare, and bursts run without any.
    task automatic idle_gap();
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        gap  = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else if (roll < 2) begin
            burst_left = $urandom_range(20, 60);
        end else if (roll < 50) begin
            gap = 0;
        end else if (roll < 85) begin
            gap = $urandom_range(1, 3);
        end else if (roll < 97) begin
            gap = $urandom_range(4, 12);
        end else begin
            gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Present one request and hold it until the engine takes it.
    task automatic issue(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                         input logic [VAL_W-1:0] val);
        start           <= 1'b1;
        i_kind          <= kind;
        i_position      <= pos;
        i_element_value <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.record_request(kind, pos, val);
        idle_gap();
    endtask

    // Hold off new requests until every predicted result has arrived.
    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (sb.outstanding() != 0);
        @(posedge i_clk);
    endtask

    // Edge cases on an empty list, a short list and after a clear.
    task automatic run_directed();
        issue(K_POP, '0, '0);
        issue(K_GET, '0, '0);
        issue(K_SET, '0, VAL_ONES);
        issue(K_REMOVE, '0, '0);
        issue(K_INSERT, 9'd1, '0);
        issue(K_INSERT, '0, VAL_ONES);
        issue(K_APPEND, '0, '0);
        issue(K_APPEND, POS_MAX, 32'hA5A5_5A5A);
        issue(K_INSERT, 9'd1, '0);
        issue(K_GET, '0, '0);
        issue(K_GET, 9'd3, '0);
        issue(K_GET, POS_MAX, VAL_ONES);
        issue(K_SET, 9'd3, 32'h0000_0000);
        issue(K_SET, 9'd2, '0);
        issue(K_COUNT, '0, '0);
        issue(K_FIRST, '0, '0);
        issue(K_LAST, '0, '0);
        issue(K_FIRST, '0, 32'h1234_5678);
        issue(K_LAST, '0, VAL_ONES);
        issue(K_REMOVE, '0, '0);
        issue(K_INSERT, 9'd3, 32'h8000_0001);
        issue(K_CLEAR, '0, '0);
        issue(K_GET, '0, '0);
        issue(K_POP, '0, '0);
        issue(KIND_UNUSED_HI, POS_MAX, VAL_ONES);
    endtask

    // Choose an operation, favoring growth or shrinkage of the list.
    function automatic logic [KIND_W-1:0] pick_kind(bit growing);
        int roll;
        roll = $urandom_range(0, 99);
        if (growing) begin
            if (roll < 50) return K_APPEND;
            if (roll < 65) return K_INSERT;
            if (roll < 69) return K_POP;
            if (roll < 72) return K_REMOVE;
            if (roll < 80) return K_GET;
            if (roll < 86) return K_SET;
            if (roll < 90) return K_COUNT;
            if (roll < 94) return K_FIRST;
            if (roll < 98) return K_LAST;
        end else begin
            if (roll < 6)  return K_APPEND;
            if (roll < 9)  return K_INSERT;
            if (roll < 44) return K_POP;
            if (roll < 64) return K_REMOVE;
            if (roll < 72) return K_GET;
            if (roll < 78) return K_SET;
            if (roll < 84) return K_COUNT;
            if (roll < 90) return K_FIRST;
            if (roll < 96) return K_LAST;
            if (roll < 98) return K_CLEAR;
        end
        return KIND_W'(KIND_UNUSED_LO + $urandom_range(0, KIND_UNUSED_HI - KIND_UNUSED_LO));
    endfunction

    // Positions mostly inside the list, often on its boundary, sometimes anywhere.
    function automatic logic [POS_W-1:0] pick_position();
        int roll;
        int len;
        roll = $urandom_range(0, 99);
        len  = sb.count_now;
        if (roll < 70) return POS_W'($urandom_range(0, len));
        if (roll < 85) return POS_W'((len > 0 && roll < 78) ? len - 1 : len);
        return POS_W'($urandom_range(0, POS_MAX));
    endfunction

    // Values from a small pool so that searches match, or copies of stored words.
    function automatic logic [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return $urandom_range(0, 7);
        if (roll < 65 && sb.count_now > 0) return sb.words[$urandom_range(0, sb.count_now - 1)];
        if (roll < 95) return $urandom;
        return VAL_ONES;
    endfunction

    // Random traffic that swings the list between empty and full.
    task automatic run_random();
        bit growing;
        bit flip;
        int n;
        growing = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            flip = 1'b0;
            if (growing && sb.count_now >= DEF_CAPACITY && $urandom_range(0, 3) == 0)
                flip = 1'b1;
            else if (!growing && sb.count_now == 0 && $urandom_range(0, 3) == 0)
                flip = 1'b1;
            else if ($urandom_range(0, 299) == 0)
                flip = 1'b1;
            if (flip) begin
                growing = !growing;
                drain();
            end
            issue(pick_kind(growing), pick_position(), pick_value());
        end
    endtask

    // Main sequence: reset, directed requests, random requests, verdict.
    initial begin
        sb         = new();
        burst_left = 0;
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_kind          <= K_APPEND;
        i_position      <= '0;
        i_element_value <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        drain();
        run_random();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("bounded_list_engine verification clean");
        end else begin
            $display("bounded_list_engine verification failed");
        end
        $finish;
    end

    // Watchdog for a hung engine.
    initial begin
        #(40_000_000);
        $display("bounded_list_engine verification failed");
        $finish;
    end

endmodule
